@@ src/ipv4fhe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ipv4fhe_pkg;

    // Default of the frame size limit.
    localparam int DEFAULT_MAX_FRAME_BYTES = 4096;

    // Field widths fixed by the descriptor format.
    localparam int LEN_W   = 13;
    localparam int ADDR_W  = 32;
    localparam int PROTO_W = 8;
    localparam int PORT_W  = 16;
    localparam int FLAGS_W = 6;
    localparam int BYTE_W  = 8;
    localparam int IHL_W   = 4;

    // Width of an L4 offset: 14 + 4 * 15 + 13 still fits in seven bits.
    localparam int L4OFF_W = 7;

    // Output tdata: descriptor fields packed from bit 0, padded to whole bytes.
    localparam int DESC_BITS = LEN_W + 2 * ADDR_W + PROTO_W + 2 * PORT_W + FLAGS_W;
    localparam int M_TDATA_W = ((DESC_BITS + 7) / 8) * 8;

    // Header layout.
    localparam int ETH_HDR_BYTES   = 14;
    localparam int ETYPE_HI_POS    = 12;
    localparam int ETYPE_LO_POS    = 13;
    localparam int PROTO_POS       = 23;
    localparam int SRC_ADDR_FIRST  = 26;
    localparam int SRC_ADDR_LAST   = 29;
    localparam int DST_ADDR_FIRST  = 30;
    localparam int DST_ADDR_LAST   = 33;
    localparam int MIN_PARSE_BYTES = 34;
    localparam int L4_PORT_BYTES   = 4;
    localparam int L4_TCP_BYTES    = 14;
    localparam int TCP_FLAGS_OFF   = 13;

    localparam logic [15:0]        ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_TCP      = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP      = 8'd17;

endpackage : ipv4fhe_pkg

`default_nettype wire

@@ src/ipv4_flow_header_extractor.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake                    | Payload
// ----------+-----+------------------------------+---------------------------------------------
// s (bytes) | in  | i_s_tvalid / o_s_tready      | i_s_tdata: data_byte; i_s_tlast: end_of_frame
// m (desc)  | out | o_m_tvalid / i_m_tready      | o_m_tdata: descriptor; o_m_tuser: parse_ok
//
// One byte beat is accepted every cycle unless the input is stalled. A beat sits in
// the input register, where it updates the header capture; the descriptor of a
// frame is registered in the output register when its last beat leaves the input register.
// i_rst_n is synchronous and active low; it clears the frame state and both
// valid flags. Only the last beat of a frame needs the output register, so a
// stalled output holds back the input only when a last beat waits for it.

module ipv4_flow_header_extractor
    import ipv4fhe_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [BYTE_W-1:0]    i_s_tdata,   // [7:0] data_byte
    input  wire logic                 i_s_tlast,   // end_of_frame

    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // [12:0] frame_length, [44:13] source_address, [76:45] destination_address,
    // [84:77] protocol_number, [100:85] source_port, [116:101] destination_port,
    // [122:117] flag_bits, [127:123] zero
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    output logic                      o_m_tuser    // [0] parse_ok
);

    // The byte counter must hold MAX_FRAME_BYTES itself.
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    // Counter widened to at least the length field, so it can be truncated.
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Frame state.
    logic [CW-1:0]      r_pos,      n_pos;
    logic [15:0]        r_etype,    n_etype;
    logic [IHL_W-1:0]   r_ihl,      n_ihl;
    logic [PROTO_W-1:0] r_proto,    n_proto;
    logic [ADDR_W-1:0]  r_src_addr, n_src_addr;
    logic [ADDR_W-1:0]  r_dst_addr, n_dst_addr;
    logic [PORT_W-1:0]  r_l4_sport, n_l4_sport;
    logic [PORT_W-1:0]  r_l4_dport, n_l4_dport;
    logic [FLAGS_W-1:0] r_flags,    n_flags;

    // Output register.
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;
    logic                 r_out_ok,   n_out_ok;

    logic                 out_free;
    logic                 advance;

    // Capture and descriptor terms.
    logic                 capture_en;
    logic [IHL_W-1:0]     ihl_now;
    logic [L4OFF_W-1:0]   l4_now;
    logic [CW-1:0]        l4_pos;
    logic [CW-1:0]        l4_end;
    logic [CW-1:0]        hdr_l4_pos;
    logic                 parse_ok;
    logic                 l4_ok;
    logic                 tcp_ok;
    logic [LW-1:0]        len_wide;

    // A non-last beat only touches the frame state; a last beat also needs
    // room in the output register.
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // Header capture for the beat in the input register. The IHL nibble is
    // taken from the current byte when that byte is the IHL byte itself, so a
    // zero IHL captures the port from the IHL byte onward.
    always_comb begin
        capture_en = r_pos < CW'(MAX_FRAME_BYTES);
        ihl_now    = (r_pos == CW'(ETH_HDR_BYTES)) ? r_in_byte[IHL_W-1:0] : r_ihl;
        l4_now     = L4OFF_W'(ETH_HDR_BYTES) + L4OFF_W'({ihl_now, 2'b00});
        l4_pos     = CW'(l4_now);

        n_pos      = r_pos;
        n_etype    = r_etype;
        n_ihl      = r_ihl;
        n_proto    = r_proto;
        n_src_addr = r_src_addr;
        n_dst_addr = r_dst_addr;
        n_l4_sport = r_l4_sport;
        n_l4_dport = r_l4_dport;
        n_flags    = r_flags;

        if (capture_en) begin
            n_pos = r_pos + CW'(1);
            if (r_pos == CW'(ETYPE_HI_POS) || r_pos == CW'(ETYPE_LO_POS)) begin
                n_etype = {r_etype[7:0], r_in_byte};
            end
            if (r_pos == CW'(ETH_HDR_BYTES)) begin
                n_ihl = r_in_byte[IHL_W-1:0];
            end
            if (r_pos == CW'(PROTO_POS)) begin
                n_proto = r_in_byte;
            end
            if (r_pos >= CW'(SRC_ADDR_FIRST) && r_pos <= CW'(SRC_ADDR_LAST)) begin
                n_src_addr = {r_src_addr[ADDR_W-BYTE_W-1:0], r_in_byte};
            end
            if (r_pos >= CW'(DST_ADDR_FIRST) && r_pos <= CW'(DST_ADDR_LAST)) begin
                n_dst_addr = {r_dst_addr[ADDR_W-BYTE_W-1:0], r_in_byte};
            end
            if (r_pos >= l4_pos && r_pos < l4_pos + CW'(2)) begin
                n_l4_sport = {r_l4_sport[PORT_W-BYTE_W-1:0], r_in_byte};
            end
            if (r_pos >= l4_pos + CW'(2) && r_pos < l4_pos + CW'(L4_PORT_BYTES)) begin
                n_l4_dport = {r_l4_dport[PORT_W-BYTE_W-1:0], r_in_byte};
            end
            if (r_pos == l4_pos + CW'(TCP_FLAGS_OFF)) begin
                n_flags = r_in_byte[FLAGS_W-1:0];
            end
        end
    end

    // Descriptor from the state as it stands after this beat.
    always_comb begin
        hdr_l4_pos = CW'(L4OFF_W'(ETH_HDR_BYTES) + L4OFF_W'({n_ihl, 2'b00}));
        l4_end     = hdr_l4_pos + CW'(L4_PORT_BYTES);
        parse_ok   = (n_pos >= CW'(MIN_PARSE_BYTES)) && (n_etype == ETHERTYPE_IPV4);
        l4_ok      = parse_ok && (n_pos >= l4_end) &&
                     (n_proto == PROTO_TCP || n_proto == PROTO_UDP);
        tcp_ok     = l4_ok && (n_proto == PROTO_TCP) &&
                     (n_pos >= hdr_l4_pos + CW'(L4_TCP_BYTES));
        len_wide   = LW'(n_pos);

        n_out_ok   = parse_ok;
        n_out_data = M_TDATA_W'({
            tcp_ok   ? n_flags    : {FLAGS_W{1'b0}},
            l4_ok    ? n_l4_dport : {PORT_W{1'b0}},
            l4_ok    ? n_l4_sport : {PORT_W{1'b0}},
            parse_ok ? n_proto    : {PROTO_W{1'b0}},
            parse_ok ? n_dst_addr : {ADDR_W{1'b0}},
            parse_ok ? n_src_addr : {ADDR_W{1'b0}},
            len_wide[LEN_W-1:0]
        });
    end

    // Frame state: updated per beat, cleared after the last beat of a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_pos      <= '0;
            r_etype    <= '0;
            r_ihl      <= '0;
            r_proto    <= '0;
            r_src_addr <= '0;
            r_dst_addr <= '0;
            r_l4_sport <= '0;
            r_l4_dport <= '0;
            r_flags    <= '0;
        end else if (advance) begin
            r_pos      <= n_pos;
            r_etype    <= n_etype;
            r_ihl      <= n_ihl;
            r_proto    <= n_proto;
            r_src_addr <= n_src_addr;
            r_dst_addr <= n_dst_addr;
            r_l4_sport <= n_l4_sport;
            r_l4_dport <= n_l4_dport;
            r_flags    <= n_flags;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_data <= n_out_data;
            r_out_ok   <= n_out_ok;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_ok;

    // The byte counter never passes the frame size limit.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= CW'(MAX_FRAME_BYTES))
        else $error("byte counter exceeds frame size limit");

    // State is back at reset once a frame's descriptor is registered.
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_pos == '0 && r_etype == '0 && r_ihl == '0))
        else $error("frame state not cleared after last beat");

    // A failed parse carries no addresses, protocol or ports.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[M_TDATA_W-1:LEN_W] == '0))
        else $error("fields set on a frame that did not parse");

    // TCP flags only appear with the TCP protocol number.
    a_flags_tcp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[122:117] != '0) |-> (o_m_tdata[84:77] == PROTO_TCP))
        else $error("flag bits set on a non-TCP descriptor");

    // The input stalls only for a last beat blocked by a held descriptor.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_in_last && r_out_valid && !i_m_tready))
        else $error("input stalled without a blocked last beat");

endmodule : ipv4_flow_header_extractor

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the IPv4 five-tuple header extractor.
//
// Frames are streamed into the slave side one byte beat at a time. Every
// accepted beat also goes through a behavioral copy of the parser that keeps
// its own byte counter and captured header fields. On the last beat that copy
// queues the descriptor the block should produce. Each descriptor accepted on
// the master side is compared field by field with the oldest queued one.
//
// The stimulus starts with directed frames: single-byte frames, TCP and UDP
// frames cut around the port and flag boundaries, failed parses and IHL
// values at both ends of the range. A short run of random frames follows,
// most of them well-formed IPv4 headers with random content. Both sides
// insert random idle cycles per beat, and the sender sometimes holds off
// until every queued descriptor has come back.

module tb;
    import ipv4fhe_pkg::*;

    localparam int MAX_BYTES = DEFAULT_MAX_FRAME_BYTES;

    // Protocol and ethertype codes that the stimulus uses beside TCP and UDP.
    localparam logic [PROTO_W-1:0] PROTO_ICMP     = 8'd1;
    localparam logic [15:0]        ETHERTYPE_IPV6 = 16'h86DD;

    // Cycles without any accepted beat before the run is declared hung. The
    // slowest legal stretch is a sender gap or a receiver stall plus the output
    // latency, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 2000;

    // Random-phase stop points.
    localparam int RANDOM_BYTES  = 200;
    localparam int RANDOM_FRAMES = 4;

    typedef struct {
        logic [LEN_W-1:0]   length;
        logic               ok;
        logic [ADDR_W-1:0]  src_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  sport;
        logic [PORT_W-1:0]  dport;
        logic [FLAGS_W-1:0] flags;
    } flow_desc_t;

    // Every input of the block starts at a known value.
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [BYTE_W-1:0]    i_s_tdata  = '0;
    logic                 i_s_tlast  = 1'b0;
    logic                 i_m_tready = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;

    ipv4_flow_header_extractor #(
        .MAX_FRAME_BYTES (MAX_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Parser copy: state of the frame currently streaming in.
    int                 byte_count;
    logic [15:0]        etype_seen;
    logic [IHL_W-1:0]   ihl_seen;
    logic [PROTO_W-1:0] proto_seen;
    logic [ADDR_W-1:0]  src_addr_seen;
    logic [ADDR_W-1:0]  dst_addr_seen;
    logic [PORT_W-1:0]  sport_seen;
    logic [PORT_W-1:0]  dport_seen;
    logic [FLAGS_W-1:0] flags_seen;

    flow_desc_t  queued_descriptors[$];
    logic [7:0]  frame_bytes[$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;

    task automatic clear_parser;
        byte_count    = 0;
        etype_seen    = '0;
        ihl_seen      = '0;
        proto_seen    = '0;
        src_addr_seen = '0;
        dst_addr_seen = '0;
        sport_seen    = '0;
        dport_seen    = '0;
        flags_seen    = '0;
    endtask

    // Feeds one accepted byte to the parser copy. Bytes past the size limit
    // are dropped, so an overlong frame looks like its first MAX_BYTES bytes.
    task automatic parse_byte(input logic [7:0] data, input logic last);
        int         cur_ihl;
        int         l4_start;
        int         len;
        bit         ok;
        bit         ports_ok;
        bit         tcp_ok;
        flow_desc_t desc;
        if (byte_count < MAX_BYTES) begin
            // The IHL byte moves the L4 window at once, so with an IHL of
            // zero the IHL byte itself is also the first source-port byte.
            cur_ihl  = (byte_count == ETH_HDR_BYTES) ? int'(data[3:0]) : int'(ihl_seen);
            l4_start = ETH_HDR_BYTES + 4 * cur_ihl;
            if (byte_count == ETYPE_HI_POS || byte_count == ETYPE_LO_POS)
                etype_seen = {etype_seen[7:0], data};
            if (byte_count == ETH_HDR_BYTES)
                ihl_seen = data[3:0];
            if (byte_count == PROTO_POS)
                proto_seen = data;
            if (byte_count >= SRC_ADDR_FIRST && byte_count <= SRC_ADDR_LAST)
                src_addr_seen = {src_addr_seen[23:0], data};
            if (byte_count >= DST_ADDR_FIRST && byte_count <= DST_ADDR_LAST)
                dst_addr_seen = {dst_addr_seen[23:0], data};
            if (byte_count >= l4_start && byte_count < l4_start + 2)
                sport_seen = {sport_seen[7:0], data};
            if (byte_count >= l4_start + 2 && byte_count < l4_start + L4_PORT_BYTES)
                dport_seen = {dport_seen[7:0], data};
            if (byte_count == l4_start + TCP_FLAGS_OFF)
                flags_seen = data[5:0];
            byte_count++;
        end
        if (last) begin
            len      = byte_count;
            l4_start = ETH_HDR_BYTES + 4 * int'(ihl_seen);
            ok       = (len >= MIN_PARSE_BYTES) && (etype_seen == ETHERTYPE_IPV4);
            ports_ok = ok && (len >= l4_start + L4_PORT_BYTES)
                       && (proto_seen == PROTO_TCP || proto_seen == PROTO_UDP);
            tcp_ok   = ports_ok && (proto_seen == PROTO_TCP)
                       && (len >= l4_start + L4_TCP_BYTES);
            desc.length   = LEN_W'(len);
            desc.ok       = ok;
            desc.src_addr = ok ? src_addr_seen : '0;
            desc.dst_addr = ok ? dst_addr_seen : '0;
            desc.proto    = ok ? proto_seen : '0;
            desc.sport    = ports_ok ? sport_seen : '0;
            desc.dport    = ports_ok ? dport_seen : '0;
            desc.flags    = tcp_ok ? flags_seen : '0;
            queued_descriptors.push_back(desc);
            clear_parser();
        end
    endtask

    task automatic compare_field(input string field_name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field_name, want, got);
            error_count++;
        end
    endtask

    task automatic check_descriptor;
        flow_desc_t want;
        if (queued_descriptors.size() == 0) begin
            $display("%0t ns: descriptor with no frame pending, expected none, actual 0x%0h",
                     $time, o_m_tdata);
            error_count++;
        end else begin
            want = queued_descriptors.pop_front();
            compare_field("frame_length",        32'(want.length),   32'(o_m_tdata[12:0]));
            compare_field("parse_ok",            32'(want.ok),       32'(o_m_tuser));
            compare_field("source_address",      want.src_addr,      o_m_tdata[44:13]);
            compare_field("destination_address", want.dst_addr,      o_m_tdata[76:45]);
            compare_field("protocol_number",     32'(want.proto),    32'(o_m_tdata[84:77]));
            compare_field("source_port",         32'(want.sport),    32'(o_m_tdata[100:85]));
            compare_field("destination_port",    32'(want.dport),    32'(o_m_tdata[116:101]));
            compare_field("flag_bits",           32'(want.flags),    32'(o_m_tdata[122:117]));
        end
    endtask

    // Both handshakes are sampled here at the rising edge. The output side is
    // checked first: a descriptor leaving now is always older than one that a
    // last beat accepted at this same edge would queue.
    always @(posedge i_clk) begin : beat_monitor
        bit any_beat;
        any_beat = 1'b0;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_descriptor();
                any_beat = 1'b1;
            end
            if (i_s_tvalid && o_s_tready) begin
                parse_byte(i_s_tdata, i_s_tlast);
                any_beat = 1'b1;
            end
        end
        quiet_cycles <= (any_beat || !i_rst_n) ? 0 : quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    // Receiver: a random stall before each descriptor, then ready until one
    // is taken. With rx_idle cleared it stays ready.
    initial begin : descriptor_sink
        int unsigned gap;
        forever begin
            gap = rx_idle ? $urandom_range(0, 9) : 0;
            @(negedge i_clk);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_rst_n));
        end
    end

    // Sends one byte beat and returns at the edge that accepts it. Valid
    // stays high into the next beat when no gap is drawn.
    task automatic send_byte(input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_frame;
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Holds the sender off until every queued descriptor has come back, then
    // lets the output latency pass.
    task automatic drain_descriptors;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (queued_descriptors.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Builds a frame with the given header codes. A negative fill gives random
    // payload, otherwise every byte but the header codes holds the fill value.
    task automatic build_frame(input int len, input logic [15:0] etype,
                               input logic [IHL_W-1:0] ihl, input logic [7:0] proto,
                               input int fill);
        frame_bytes.delete();
        for (int i = 0; i < len; i++)
            frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        if (len > ETYPE_HI_POS)
            frame_bytes[ETYPE_HI_POS] = etype[15:8];
        if (len > ETYPE_LO_POS)
            frame_bytes[ETYPE_LO_POS] = etype[7:0];
        if (len > ETH_HDR_BYTES)
            frame_bytes[ETH_HDR_BYTES] = {4'h4, ihl};
        if (len > PROTO_POS)
            frame_bytes[PROTO_POS] = proto;
    endtask

    // A one-byte frame still yields a descriptor, with parse_ok low.
    task automatic test_single_byte_frames;
        build_frame(1, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'h00);
        send_frame();
        build_frame(1, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'hFF);
        send_frame();
        build_frame(2, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, -1);
        send_frame();
        drain_descriptors();
    endtask

    // TCP frames cut just below and at the port and flag boundaries.
    task automatic test_tcp_boundaries;
        int lens[4] = '{37, 38, 47, 48};
        foreach (lens[i]) begin
            build_frame(lens[i], ETHERTYPE_IPV4, 4'd5, PROTO_TCP, -1);
            send_frame();
        end
        // All-ones payload: every flag set and the maximum port and address.
        build_frame(48, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 8'hFF);
        send_frame();
        drain_descriptors();
    endtask

    // UDP gets ports but never flags; other protocols get neither.
    task automatic test_other_protocols;
        build_frame(37, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, -1);
        send_frame();
        build_frame(38, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, -1);
        send_frame();
        build_frame(48, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 8'hFF);
        send_frame();
        build_frame(48, ETHERTYPE_IPV4, 4'd5, 8'hFF, -1);
        send_frame();
        drain_descriptors();
    endtask

    // A failed parse must zero every captured field.
    task automatic test_failed_parse;
        build_frame(MIN_PARSE_BYTES - 1, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, -1);
        send_frame();
        build_frame(40, ETHERTYPE_IPV6, 4'd5, PROTO_TCP, -1);
        send_frame();
        build_frame(40, ETHERTYPE_IPV4 | 16'h0001, 4'd5, PROTO_TCP, -1);
        send_frame();
        build_frame(40, 16'hFFFF, 4'hF, 8'hFF, 8'hFF);
        send_frame();
        build_frame(40, 16'h0000, 4'h0, 8'h00, 8'h00);
        send_frame();
        drain_descriptors();
    endtask

    // IHL below five pulls the L4 window into the IP header; with zero the IHL
    // byte is a port byte. IHL fifteen puts the window as far out as it goes.
    task automatic test_ihl_extremes;
        for (int ihl = 0; ihl < 5; ihl++) begin
            build_frame(MIN_PARSE_BYTES, ETHERTYPE_IPV4, IHL_W'(ihl), PROTO_TCP, -1);
            send_frame();
        end
        build_frame(77, ETHERTYPE_IPV4, 4'hF, PROTO_TCP, -1);
        send_frame();
        build_frame(88, ETHERTYPE_IPV4, 4'hF, PROTO_TCP, -1);
        send_frame();
        drain_descriptors();
    endtask

    // Random traffic: mostly IPv4 headers with random content and lengths
    // that straddle the port and flag boundaries, plus short frames, noise and
    // frames whose ethertype is one bit off.
    task automatic test_random_traffic;
        int unsigned       bytes_sent;
        int unsigned       frames_sent;
        int unsigned       kind;
        int unsigned       sel;
        int                l4_start;
        logic [IHL_W-1:0]  ihl;
        logic [7:0]        proto;
        bytes_sent  = 0;
        frames_sent = 0;
        while (bytes_sent < RANDOM_BYTES || frames_sent < RANDOM_FRAMES) begin
            tx_idle  = ($urandom_range(0, 3) != 0);
            rx_idle  = ($urandom_range(0, 3) != 0);
            kind     = $urandom_range(0, 9);
            sel      = $urandom_range(0, 7);
            ihl      = ($urandom_range(0, 3) != 0) ? 4'd5 : IHL_W'($urandom_range(0, 15));
            proto    = (sel < 3) ? PROTO_TCP :
                       (sel < 6) ? PROTO_UDP :
                       (sel == 6) ? PROTO_ICMP : 8'($urandom);
            l4_start = ETH_HDR_BYTES + 4 * int'(ihl);
            case (kind)
                7: begin
                    build_frame($urandom_range(1, MIN_PARSE_BYTES - 1), ETHERTYPE_IPV4,
                                ihl, proto, -1);
                end
                8: begin
                    build_frame($urandom_range(1, 80), 16'($urandom), IHL_W'($urandom),
                                8'($urandom), -1);
                end
                9: begin
                    build_frame($urandom_range(MIN_PARSE_BYTES, 100),
                                ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15)),
                                ihl, proto, -1);
                end
                default: begin
                    build_frame($urandom_range(MIN_PARSE_BYTES, l4_start + L4_TCP_BYTES + 6),
                                ETHERTYPE_IPV4, ihl, proto, -1);
                end
            endcase
            send_frame();
            bytes_sent  += frame_bytes.size();
            frames_sent++;
            if ($urandom_range(0, 7) == 0)
                drain_descriptors();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin : test_sequence
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_byte_frames();
        test_tcp_boundaries();
        test_other_protocols();
        test_failed_parse();
        test_ihl_extremes();
        test_random_traffic();

        drain_descriptors();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
